// ===== rtl/hfsc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the HDLC framer/deframer: byte type, framing constants,
// CRC-16 byte update and escape helpers. No dependencies.
package hfsc_pkg;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic  two;
        t_byte first;
        t_byte second;
    } t_stuff;

    localparam int    MaxResults = 7;
    localparam int    CntW       = $clog2(MaxResults + 1);
    localparam t_byte FlagByte   = 8'h7E;
    localparam t_byte EscByte    = 8'h7D;
    localparam t_byte EscXor     = 8'h20;
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'h8408;
    localparam logic ModeFrame   = 1'b0;
    localparam logic ModeDeframe = 1'b1;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input t_byte b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic t_stuff stuff(input t_byte b);
        t_stuff s;
        if (b == EscByte || b == FlagByte) begin
            s.two    = 1'b1;
            s.first  = EscByte;
            s.second = b ^ EscXor;
        end else begin
            s.two    = 1'b0;
            s.first  = b;
            s.second = b;
        end
        return s;
    endfunction

endpackage

// ===== rtl/hfsc_in_if.sv =====
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with payload byte and last flag.
// Depends on hfsc_pkg.
interface hfsc_in_if import hfsc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/hfsc_out_if.sv =====
`timescale 1ns / 1ps
// Result item channel: valid/ready handshake with output byte and markers.
// Depends on hfsc_pkg.
interface hfsc_out_if import hfsc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  frame_end;
    logic  run_last;

    modport source (output valid, output out_byte, output frame_end, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input frame_end, input run_last,
                    output ready);
endinterface

// ===== rtl/hdlc_frame_stuffer_crc16_unit.sv =====
`timescale 1ns / 1ps
// Top level of the HDLC async framer/deframer with CRC-16/X.25.
// Depends on hfsc_pkg, hfsc_in_if, hfsc_out_if.
//
// Mode 0 frames payload bytes: each byte is escaped (0x7D/0x7E become 0x7D,
// byte^0x20) and folded into a reflected CRC-16; last_byte appends the
// inverted CRC (low byte first, escaped) and a 0x7E flag marked frame_end.
// Mode 1 removes escapes, holds back the two bytes before each 0x7E and
// drops them as the CRC (not checked), then gives one frame_end result with
// byte 0. run_last marks the final result of each input item. An accepted
// item is expanded combinationally into a result shift register of up to 7
// bytes, which drains one result per cycle while o_out.ready is high; the next
// item is taken in the cycle the last result of the previous one leaves.
// Write the mode register only while the block is idle.
module hdlc_frame_stuffer_crc16_unit
    import hfsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    hfsc_in_if.sink     i_in,
    hfsc_out_if.source  o_out
);

    logic              r_mode;
    logic [15:0]       r_crc,  n_crc;
    logic              r_esc,  n_esc;
    logic [1:0]        r_hcnt, n_hcnt;
    t_byte             r_h0,   n_h0;
    t_byte             r_h1,   n_h1;
    t_byte             r_buf [MaxResults];
    t_byte             n_buf [MaxResults];
    logic [CntW-1:0]   r_cnt,  n_cnt;
    logic              r_fe,   n_fe;

    t_byte             w_list [MaxResults];
    logic [CntW-1:0]   w_len;
    logic              w_fe;
    logic [15:0]       w_crc;
    logic [15:0]       w_fin;
    t_byte             w_tok [3];
    t_stuff            w_st;
    logic              w_push;
    t_byte             w_pval;
    logic              w_acc;
    logic              w_pop;

    assign w_pop       = o_out.valid & o_out.ready;
    assign i_in.ready  = (r_cnt == '0) || ((r_cnt == CntW'(1)) && o_out.ready);
    assign w_acc       = i_in.valid & i_in.ready;

    assign o_out.valid     = (r_cnt != '0);
    assign o_out.out_byte  = r_buf[0];
    assign o_out.run_last  = (r_cnt == CntW'(1));
    assign o_out.frame_end = r_fe & (r_cnt == CntW'(1));

    // per-item expansion
    always_comb begin
        for (int i = 0; i < MaxResults; i++) begin
            w_list[i] = '0;
        end
        w_len  = '0;
        w_fe   = 1'b0;
        n_crc  = r_crc;
        n_esc  = r_esc;
        n_hcnt = r_hcnt;
        n_h0   = r_h0;
        n_h1   = r_h1;
        w_push = 1'b0;
        w_pval = i_in.data_byte;
        w_crc  = crc_update(r_crc, i_in.data_byte);
        w_fin  = ~w_crc;
        w_tok[0] = i_in.data_byte;
        w_tok[1] = w_fin[7:0];
        w_tok[2] = w_fin[15:8];
        w_st   = '0;

        if (r_mode == ModeFrame) begin
            for (int k = 0; k < 3; k++) begin
                if (k == 0 || i_in.last_byte) begin
                    w_st = stuff(w_tok[k]);
                    w_list[w_len[2:0]] = w_st.first;
                    w_len = w_len + CntW'(1);
                    if (w_st.two) begin
                        w_list[w_len[2:0]] = w_st.second;
                        w_len = w_len + CntW'(1);
                    end
                end
            end
            if (i_in.last_byte) begin
                w_list[w_len[2:0]] = FlagByte;
                w_len = w_len + CntW'(1);
                w_fe  = 1'b1;
                n_crc = CrcInit;
            end else begin
                n_crc = w_crc;
            end
        end else begin
            if (r_esc) begin
                n_esc  = 1'b0;
                w_push = 1'b1;
                w_pval = i_in.data_byte ^ EscXor;
            end else if (i_in.data_byte == FlagByte) begin
                n_hcnt    = 2'd0;
                w_list[0] = '0;
                w_len     = CntW'(1);
                w_fe      = 1'b1;
            end else if (i_in.data_byte == EscByte) begin
                n_esc = 1'b1;
            end else begin
                w_push = 1'b1;
            end
            if (w_push) begin
                if (r_hcnt == 2'd2) begin
                    w_list[0] = r_h0;
                    w_len     = CntW'(1);
                    n_h0      = r_h1;
                    n_h1      = w_pval;
                end else begin
                    if (r_hcnt == 2'd0) begin
                        n_h0 = w_pval;
                    end else begin
                        n_h1 = w_pval;
                    end
                    n_hcnt = r_hcnt + 2'd1;
                end
            end
        end
    end

    // result shift register
    always_comb begin
        n_cnt = r_cnt;
        n_fe  = r_fe;
        for (int i = 0; i < MaxResults; i++) begin
            n_buf[i] = r_buf[i];
        end
        if (w_acc) begin
            n_cnt = w_len;
            n_fe  = w_fe;
            for (int i = 0; i < MaxResults; i++) begin
                n_buf[i] = w_list[i];
            end
        end else if (w_pop) begin
            n_cnt = r_cnt - CntW'(1);
            for (int i = 0; i < MaxResults - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            n_buf[MaxResults - 1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeFrame;
            r_crc  <= CrcInit;
            r_esc  <= 1'b0;
            r_hcnt <= 2'd0;
            r_cnt  <= '0;
            r_fe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (w_acc) begin
                r_crc  <= n_crc;
                r_esc  <= n_esc;
                r_hcnt <= n_hcnt;
            end
            r_cnt <= n_cnt;
            r_fe  <= n_fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
        end
        for (int i = 0; i < MaxResults; i++) begin
            r_buf[i] <= n_buf[i];
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hdlc_frame_stuffer_crc16_unit: framing and deframing
// traffic with random stalls on both channels, checked against a built-in predictor.
// Depends on hfsc_pkg, hfsc_in_if, hfsc_out_if and the RTL top level.
module tb;
    import hfsc_pkg::*;

    typedef struct {
        t_byte data;
        logic  last;
    } t_item;

    typedef struct {
        t_byte out_byte;
        logic  frame_end;
        logic  run_last;
    } t_result;

    localparam int CycleLimit = 200000;
    localparam int DrainWait  = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_data;

    hfsc_in_if  in_ch ();
    hfsc_out_if out_ch ();

    hdlc_frame_stuffer_crc16_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #1 i_clk = ~i_clk;

    t_item   tx_items[$];
    t_result rx_expect[$];
    t_result step_out[$];
    t_item   nxt;
    t_result got;
    t_result want;

    int   n_queued   = 0;
    int   n_accepted = 0;
    int   errors     = 0;
    int   cycles     = 0;
    int   in_gap     = 0;
    int   out_gap    = 0;
    logic idle_en    = 1'b1;
    logic in_fire    = 1'b0;

    // predictor state
    logic        cur_mode;
    logic [15:0] crc_acc;
    logic        esc_pend;
    t_byte       held[2];
    int          held_cnt;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input t_byte b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        return c;
    endfunction

    function automatic t_byte rand_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return EscByte;
        if (sel == 1) return FlagByte;
        return t_byte'($urandom_range(0, 255));
    endfunction

    task automatic add_result(input t_byte b, input logic fe);
        t_result r;
        r.out_byte  = b;
        r.frame_end = fe;
        r.run_last  = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic add_stuffed(input t_byte b);
        if (b == EscByte || b == FlagByte) begin
            add_result(EscByte, 1'b0);
            add_result(b ^ EscXor, 1'b0);
        end else begin
            add_result(b, 1'b0);
        end
    endtask

    task automatic hold_byte(input t_byte b);
        if (held_cnt >= 2) begin
            add_result(held[0], 1'b0);
            held[0] = held[1];
            held[1] = b;
        end else begin
            held[held_cnt] = b;
            held_cnt++;
        end
    endtask

    task automatic predict_stream(input t_byte b, input logic last);
        logic [15:0] fin;
        step_out.delete();
        if (cur_mode == ModeFrame) begin
            crc_acc = crc_step(crc_acc, b);
            add_stuffed(b);
            if (last) begin
                fin = ~crc_acc;
                add_stuffed(fin[7:0]);
                add_stuffed(fin[15:8]);
                add_result(FlagByte, 1'b1);
                crc_acc = CrcInit;
            end
        end else if (esc_pend) begin
            esc_pend = 1'b0;
            hold_byte(b ^ EscXor);
        end else if (b == FlagByte) begin
            held_cnt = 0;
            add_result(8'h00, 1'b1);
        end else if (b == EscByte) begin
            esc_pend = 1'b1;
        end else begin
            hold_byte(b);
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
        foreach (step_out[i]) rx_expect.push_back(step_out[i]);
    endtask

    task automatic report(input string what, input int exp_v, input int got_v);
        $display("MISMATCH @%0t %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (tx_items.size() > 0) begin
                nxt = tx_items.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.data_byte <= nxt.data;
                in_ch.last_byte <= nxt.last;
                if (idle_en && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 13);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (idle_en && $urandom_range(0, 6) == 0) out_gap <= $urandom_range(1, 13);
        end
    end

    // accept tracking and result monitor
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            n_accepted++;
            predict_stream(in_ch.data_byte, in_ch.last_byte);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.out_byte  = out_ch.out_byte;
            got.frame_end = out_ch.frame_end;
            got.run_last  = out_ch.run_last;
            if (rx_expect.size() == 0) begin
                report("unexpected item, out_byte", 0, got.out_byte);
            end else begin
                want = rx_expect.pop_front();
                if (got.out_byte !== want.out_byte)
                    report("out_byte", want.out_byte, got.out_byte);
                if (got.frame_end !== want.frame_end)
                    report("frame_end", want.frame_end, got.frame_end);
                if (got.run_last !== want.run_last)
                    report("run_last", want.run_last, got.run_last);
            end
        end
    end

    task automatic queue_item(input t_byte b, input logic last);
        t_item it;
        it.data = b;
        it.last = last;
        tx_items.push_back(it);
        n_queued++;
    endtask

    task automatic queue_line_byte(input t_byte b);
        if (b == EscByte || b == FlagByte) begin
            queue_item(EscByte, 1'($urandom_range(0, 1)));
            queue_item(b ^ EscXor, 1'($urandom_range(0, 1)));
        end else begin
            queue_item(b, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        while (!(n_accepted == n_queued && rx_expect.size() == 0)) @(posedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cur_mode = m;
    endtask

    task automatic frame_phase(input int n_items);
        int    start;
        int    len;
        logic  partial;
        start = n_queued;
        while (n_queued - start < n_items) begin
            len     = $urandom_range(1, 10);
            partial = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < len; i++) queue_item(rand_byte(), (i == len - 1) && !partial);
        end
    endtask

    task automatic deframe_phase(input int n_items);
        int          start;
        int          len;
        logic [15:0] crc;
        t_byte       b;
        start = n_queued;
        while (n_queued - start < n_items) begin
            if ($urandom_range(0, 4) != 0) begin
                len = $urandom_range(0, 8);
                crc = CrcInit;
                for (int i = 0; i < len; i++) begin
                    b   = rand_byte();
                    crc = crc_step(crc, b);
                    queue_line_byte(b);
                end
                crc = ~crc;
                queue_line_byte(crc[7:0]);
                queue_line_byte(crc[15:8]);
                queue_item(FlagByte, 1'($urandom_range(0, 1)));
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) queue_item(rand_byte(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        logic [15:0] fin;
        t_byte       lo_a, lo_b, hi_a, hi_b;
        logic        got_lo, got_hi;

        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = 1'b0;
        i_rst_n         = 1'b0;
        cur_mode        = ModeFrame;
        crc_acc         = CrcInit;
        esc_pend        = 1'b0;
        held_cnt        = 0;

        // two-byte payloads whose CRC bytes need escaping
        got_lo = 1'b0;
        got_hi = 1'b0;
        lo_a = 0; lo_b = 0; hi_a = 0; hi_b = 0;
        for (int a = 0; a < 256; a++) begin
            for (int b = 0; b < 256; b++) begin
                fin = ~crc_step(crc_step(CrcInit, t_byte'(a)), t_byte'(b));
                if (!got_lo && (fin[7:0] == EscByte || fin[7:0] == FlagByte)) begin
                    got_lo = 1'b1; lo_a = t_byte'(a); lo_b = t_byte'(b);
                end
                if (!got_hi && (fin[15:8] == EscByte || fin[15:8] == FlagByte)) begin
                    got_hi = 1'b1; hi_a = t_byte'(a); hi_b = t_byte'(b);
                end
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(ModeFrame);

        // framing: minimal frame, byte extremes, escapes, escaped CRC bytes
        queue_item(8'h00, 1'b1);
        queue_item(8'hFF, 1'b0);
        queue_item(EscByte, 1'b0);
        queue_item(FlagByte, 1'b0);
        queue_item(8'h80, 1'b0);
        queue_item(8'h01, 1'b1);
        queue_item(lo_a, 1'b0);
        queue_item(lo_b, 1'b1);
        queue_item(hi_a, 1'b0);
        queue_item(hi_b, 1'b1);
        wait_drained();

        set_mode(ModeDeframe);
        // deframing: empty and short frames, escaped flag/escape, ignored last
        queue_item(FlagByte, 1'b0);
        queue_item(8'h41, 1'b0);
        queue_item(FlagByte, 1'b0);
        queue_item(EscByte, 1'b0);
        queue_item(8'h5E, 1'b0);
        queue_item(EscByte, 1'b0);
        queue_item(FlagByte, 1'b0);
        queue_item(EscByte, 1'b0);
        queue_item(EscByte, 1'b0);
        queue_item(8'h00, 1'b1);
        queue_item(8'hFF, 1'b1);
        queue_item(FlagByte, 1'b1);
        wait_drained();

        set_mode(ModeFrame);
        frame_phase(40);
        wait_drained();
        set_mode(ModeDeframe);
        deframe_phase(40);
        wait_drained();
        set_mode(ModeFrame);
        frame_phase(35);
        wait_drained();
        set_mode(ModeDeframe);
        deframe_phase(35);
        wait_drained();

        idle_en = 1'b0;
        set_mode(ModeFrame);
        frame_phase(30);
        wait_drained();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
